// ===== rtl/crc32lt_pkg.sv =====
package crc32lt_pkg;

	localparam int unsigned CRC_W       = 32;
	localparam int unsigned OUT_COUNT_W = 40;
	localparam int unsigned BYTE_W      = 8;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	// request kinds carried on the input side
	localparam logic REQ_DATA   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic data_en;   // fold an accepted data byte, bump the count
		logic trl_start; // finish accepted, load the trailer shifter
		logic trl_step;  // fold the low count byte and shift the trailer down
		logic emit;      // load the result register and clear the stream state
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rem_zero; // trailer shifter has run out of count bytes
	} dp_stat_t;

	// one byte of reflected crc-32, lsb first
	function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] byte_in);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, byte_in};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc32lt_ctrl.sv =====
module crc32lt_ctrl
	import crc32lt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_kind,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output ctrl_cmd_t  cmd,
	input  dp_stat_t   stat
);

	localparam logic ST_RUN   = 1'b0;
	localparam logic ST_TRAIL = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic in_fire;
	logic out_free;

	assign in_ready  = (state_q == ST_RUN);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_fire) begin
					if (in_kind == REQ_FINISH) begin
						cmd.trl_start = 1'b1;
						state_d       = ST_TRAIL;
					end else begin
						cmd.data_en = 1'b1;
					end
				end
			end
			ST_TRAIL: begin
				if (!stat.rem_zero) begin
					cmd.trl_step = 1'b1;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/crc32lt_dp.sv =====
module crc32lt_dp
	import crc32lt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	input  logic [BYTE_W-1:0]      data_byte,
	output dp_stat_t               stat,
	output logic [CRC_W-1:0]       checksum,
	output logic [OUT_COUNT_W-1:0] byte_count
);

	logic [CRC_W-1:0]       crc_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [CRC_W-1:0]       checksum_q;
	logic [OUT_COUNT_W-1:0] byte_count_q;
	logic [64:0]            count_ext;

	// zero-extend past the output width, then keep the low bits
	assign count_ext     = {{(65-COUNT_WIDTH){1'b0}}, count_q};
	assign stat.rem_zero = (rem_q == '0);
	assign checksum      = checksum_q;
	assign byte_count    = byte_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.data_en) begin
				crc_q <= fold_byte(crc_q, data_byte);
				if (count_q != '1) begin
					count_q <= count_q + COUNT_WIDTH'(1);
				end
			end
			if (cmd.trl_start) begin
				rem_q <= count_q;
			end
			if (cmd.trl_step) begin
				crc_q <= fold_byte(crc_q, rem_q[BYTE_W-1:0]);
				rem_q <= rem_q >> BYTE_W;
			end
			if (cmd.emit) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			checksum_q   <= ~crc_q;
			byte_count_q <= count_ext[OUT_COUNT_W-1:0];
		end
	end

endmodule

// ===== rtl/crc32_with_length_trailer_core.sv =====
// channel | dir | tdata (low bit up)                 | tuser
// s_*     | in  | data_byte[7:0]                     | req_type (0 data, 1 finish)
// m_*     | out | checksum[31:0], byte_count[71:32]  | none
//
// data beats are taken one per cycle with no gaps while no finish beat is in progress
// a finish beat loads the trailer shifter, then folds each count byte up to the highest nonzero
// one (up to COUNT_WIDTH/8 rounded up), then loads the result register
// s_tready drops while the trailer folds or while a finished result waits on a full
// result register; data of the next stream is taken while the result waits
// reset clears the crc to all ones, the count to zero and the result valid flag
module crc32_with_length_trailer_core
	import crc32lt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tuser,   // req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // checksum[31:0], byte_count[71:32]
);

	ctrl_cmd_t              cmd;
	dp_stat_t               stat;
	logic [CRC_W-1:0]       checksum;
	logic [OUT_COUNT_W-1:0] byte_count;

	// sequencer: run state takes beats, trailer state folds count bytes
	crc32lt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// crc, saturating counter, trailer shifter and result register
	crc32lt_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (s_tdata),
		.stat       (stat),
		.checksum   (checksum),
		.byte_count (byte_count)
	);

	assign m_tdata = {byte_count, checksum};

endmodule
